[hdl/baq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package baq_pkg;

  localparam int unsigned ACCOUNTS_DEF   = 1024;
  localparam int unsigned BUCKETS_DEF    = 40;
  localparam int unsigned HOURS_MIN      = 1;
  localparam int unsigned HOURS_MAX      = 168;
  localparam int unsigned SEC_PER_HOUR   = 3600;
  localparam int unsigned SLICES         = 24;
  localparam int unsigned MIN_SLICE_SEC  = 60;
  localparam int unsigned SLICE_PER_HOUR = SEC_PER_HOUR / SLICES;

  localparam logic [30:0] CAP31 = 31'h7FFF_FFFF;

  localparam logic [1:0] V_OK  = 2'd0;
  localparam logic [1:0] V_MSG = 2'd1;
  localparam logic [1:0] V_RCP = 2'd2;

  typedef struct packed {
    logic accept;
    logic meta;
    logic rd;
    logic ev;
    logic check;
    logic commit;
    logic finish;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic skip;
    logic fill_zero;
    logic walk_last;
    logic div_done;
    logic out_free;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

[hdl/baq_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module baq_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [15:0]      rem
);
  logic [31:0] num_r;
  logic [15:0] den_r;
  logic [15:0] rem_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [16:0] trial;

  // restoring, one quotient bit per cycle; only the remainder is kept
  assign trial = {rem_r, num_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      den_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[30:0], 1'b0};
      if (trial >= {1'b0, den_r}) rem_r <= 16'(trial - {1'b0, den_r});
      else rem_r <= trial[15:0];
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

[hdl/baq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module baq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire baq_pkg::sts_t sts,
  output baq_pkg::cmd_t      cmd,
  output logic               in_stall
);
  import baq_pkg::*;

  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_META   = 3'd2;
  localparam logic [2:0] S_RD     = 3'd3;
  localparam logic [2:0] S_EV     = 3'd4;
  localparam logic [2:0] S_CHECK  = 3'd5;
  localparam logic [2:0] S_COMMIT = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_META;
        end
      end
      S_META: begin
        cmd.meta = 1'b1;
        if (sts.skip) state_nxt = S_FINISH;
        else if (sts.fill_zero) state_nxt = S_CHECK;
        else state_nxt = S_RD;
      end
      S_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = S_EV;
      end
      S_EV: begin
        cmd.ev    = 1'b1;
        state_nxt = sts.walk_last ? S_CHECK : S_RD;
      end
      S_CHECK: begin
        if (sts.div_done) begin
          cmd.check = 1'b1;
          state_nxt = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else state_r <= state_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  a_accept_meta: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid) |=> (state_r == S_META))
    else $error("request accepted but metadata step skipped");
  a_commit_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMMIT) |=> (state_r == S_FINISH))
    else $error("commit not followed by finish");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.meta, cmd.rd, cmd.ev, cmd.check, cmd.commit,
              cmd.finish, cmd.clr}))
    else $error("overlapping datapath commands");
endmodule
`default_nettype wire

[hdl/baq_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module baq_dp #(
  parameter int unsigned ACCOUNTS = baq_pkg::ACCOUNTS_DEF,
  parameter int unsigned BUCKETS  = baq_pkg::BUCKETS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire baq_pkg::cmd_t cmd,
  output baq_pkg::sts_t      sts,
  input  wire logic [9:0]    in_account_index,
  input  wire logic          in_add_messages,
  input  wire logic [15:0]   in_add_recipients,
  input  wire logic [30:0]   in_message_limit,
  input  wire logic [30:0]   in_recipient_limit,
  input  wire logic [7:0]    in_period_hours,
  input  wire logic [31:0]   in_now_seconds,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic [1:0]         out_verdict,
  output logic [30:0]        out_total_messages,
  output logic [30:0]        out_total_recipients
);
  import baq_pkg::*;

  localparam int unsigned SLOTS = ACCOUNTS * BUCKETS;
  localparam int unsigned ACW   = $clog2(ACCOUNTS);
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned HW    = $clog2(BUCKETS);
  localparam int unsigned FW    = $clog2(BUCKETS + 1);
  localparam int unsigned SW    = 31 + $clog2(BUCKETS) + 1;

  typedef struct packed {
    logic [31:0] start;
    logic [30:0] mc;
    logic [30:0] rc;
  } bucket_t;

  typedef struct packed {
    logic [HW-1:0] head;
    logic [FW-1:0] fill;
  } meta_t;

  bucket_t bk_mem [SLOTS];
  meta_t   meta_mem [ACCOUNTS];

  function automatic logic [HW-1:0] wrap(input logic [HW:0] v);
    logic [HW:0] r;
    r = (v >= (HW+1)'(BUCKETS)) ? v - (HW+1)'(BUCKETS) : v;
    return r[HW-1:0];
  endfunction

  function automatic logic [30:0] sat31(input logic [31:0] v);
    return (v > {1'b0, CAP31}) ? CAP31 : v[30:0];
  endfunction

  // request capture
  logic [ACW-1:0] acct_r;
  logic [AW-1:0]  base_r;
  logic           addm_r;
  logic [15:0]    addr_r;
  logic [30:0]    maxm_r, maxr_r;
  logic [7:0]     hours_r;
  logic [31:0]    now_r;
  logic           skip_r;
  logic [31:0]    acct_ext;

  assign acct_ext = {22'd0, in_account_index};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acct_r  <= acct_ext[ACW-1:0];
      base_r  <= AW'(acct_ext[ACW-1:0]) * AW'(BUCKETS);
      addm_r  <= in_add_messages;
      addr_r  <= in_add_recipients;
      maxm_r  <= in_message_limit;
      maxr_r  <= in_recipient_limit;
      hours_r <= in_period_hours;
      now_r   <= in_now_seconds;
      skip_r  <= ((in_message_limit == '0) && (in_recipient_limit == '0)) ||
                 (acct_ext >= ACCOUNTS);
    end
  end

  // period and slice length
  logic [7:0]  hours_c;
  logic [15:0] slice_raw, slice_sec;
  logic [19:0] period_r;

  always_comb begin
    if (hours_r < 8'(HOURS_MIN)) hours_c = 8'(HOURS_MIN);
    else if (hours_r > 8'(HOURS_MAX)) hours_c = 8'(HOURS_MAX);
    else hours_c = hours_r;
    slice_raw = 16'(hours_c) * 16'(SLICE_PER_HOUR);
    slice_sec = (slice_raw < 16'(MIN_SLICE_SEC)) ? 16'(MIN_SLICE_SEC) : slice_raw;
  end

  logic        div_done;
  logic [15:0] div_rem;

  baq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.meta & ~skip_r),
    .dividend (now_r),
    .divisor  (slice_sec),
    .done     (div_done),
    .rem      (div_rem)
  );

  // metadata store, cleared by a sweep after reset
  meta_t          meta_rd_r;
  meta_t          meta_wd;
  logic           meta_we;
  logic [ACW-1:0] clr_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) meta_rd_r <= meta_mem[acct_ext[ACW-1:0]];
    if (cmd.clr) meta_mem[clr_r] <= '0;
    else if (meta_we) meta_mem[acct_r] <= meta_wd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_r <= '0;
    else if (cmd.clr) clr_r <= clr_r + 1'b1;
  end

  // ring walk
  logic [HW-1:0] orig_head_r, head_r, i_r, cur_slot_r, newest_slot_r;
  logic [FW-1:0] fill_orig_r, kept_r;
  logic          aging_r;
  logic [SW-1:0] tm_r, tr_r;
  logic [31:0]   newest_start_r;
  logic [30:0]   newest_mc_r, newest_rc_r;
  logic [AW-1:0] cur_addr_r;
  bucket_t       bk_rd_r;
  logic [HW-1:0] rd_slot;
  logic [31:0]   ev_start;
  logic          ev_old;

  assign rd_slot  = wrap({1'b0, orig_head_r} + {1'b0, i_r});
  assign ev_start = (bk_rd_r.start > now_r) ? now_r : bk_rd_r.start;
  assign ev_old   = aging_r && ({1'b0, ev_start} + 33'(period_r) <= {1'b0, now_r});

  // result of the check
  logic [1:0]  verdict_r;
  logic [30:0] totm_r, totr_r;
  logic [31:0] start_r;
  logic        allow_r;
  logic [30:0] tm_sat, tr_sat;
  logic        m_fail, r_fail;

  assign tm_sat = (tm_r > SW'(CAP31)) ? CAP31 : tm_r[30:0];
  assign tr_sat = (tr_r > SW'(CAP31)) ? CAP31 : tr_r[30:0];
  assign m_fail = (maxm_r != '0) && ({1'b0, tm_sat} + 32'(addm_r) > {1'b0, maxm_r});
  assign r_fail = (maxr_r != '0) && ({1'b0, tr_sat} + 32'(addr_r) > {1'b0, maxr_r});

  // commit decisions
  logic [31:0]   st_v;
  logic          push, full;
  logic [HW-1:0] h2, push_slot;
  logic [FW-1:0] k2;
  bucket_t       bk_wd;
  logic          bk_we;
  logic [AW-1:0] bk_wa;

  always_comb begin
    st_v = ((kept_r != '0) && (start_r < newest_start_r)) ? newest_start_r : start_r;
    push = (kept_r == '0) || (newest_start_r != st_v);
    full = (kept_r == FW'(BUCKETS));
    h2   = full ? wrap({1'b0, head_r} + 1'b1) : head_r;
    k2   = full ? kept_r - 1'b1 : kept_r;
    push_slot = wrap({1'b0, h2} + (HW+1)'(k2));

    bk_we   = 1'b0;
    bk_wa   = cur_addr_r;
    bk_wd   = bk_rd_r;
    meta_we = 1'b0;
    meta_wd = '{head: head_r, fill: kept_r};
    if (cmd.ev) begin
      bk_wd.start = now_r;
      bk_we       = (bk_rd_r.start > now_r);
    end else if (cmd.commit) begin
      meta_we = 1'b1;
      if (allow_r) begin
        bk_we = 1'b1;
        if (push) begin
          bk_wa   = base_r + AW'(push_slot);
          bk_wd   = '{start: st_v, mc: 31'(addm_r), rc: 31'(addr_r)};
          meta_wd = '{head: h2, fill: k2 + 1'b1};
        end else begin
          bk_wa = base_r + AW'(newest_slot_r);
          bk_wd = '{start: newest_start_r,
                    mc: sat31({1'b0, newest_mc_r} + 32'(addm_r)),
                    rc: sat31({1'b0, newest_rc_r} + 32'(addr_r))};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      bk_rd_r    <= bk_mem[base_r + AW'(rd_slot)];
      cur_addr_r <= base_r + AW'(rd_slot);
      cur_slot_r <= rd_slot;
    end
    if (bk_we) bk_mem[bk_wa] <= bk_wd;
  end

  always_ff @(posedge clk) begin
    if (cmd.meta) begin
      period_r    <= 20'(hours_c) * 20'(SEC_PER_HOUR);
      orig_head_r <= meta_rd_r.head;
      head_r      <= meta_rd_r.head;
      fill_orig_r <= meta_rd_r.fill;
      kept_r      <= meta_rd_r.fill;
      i_r         <= '0;
      aging_r     <= 1'b1;
      tm_r        <= '0;
      tr_r        <= '0;
      verdict_r   <= V_OK;
      totm_r      <= '0;
      totr_r      <= '0;
    end
    if (cmd.ev) begin
      i_r <= i_r + 1'b1;
      if (ev_old) begin
        head_r <= wrap({1'b0, head_r} + 1'b1);
        kept_r <= kept_r - 1'b1;
      end else begin
        aging_r        <= 1'b0;
        tm_r           <= tm_r + SW'(bk_rd_r.mc);
        tr_r           <= tr_r + SW'(bk_rd_r.rc);
        newest_start_r <= ev_start;
        newest_mc_r    <= bk_rd_r.mc;
        newest_rc_r    <= bk_rd_r.rc;
        newest_slot_r  <= cur_slot_r;
      end
    end
    if (cmd.check) begin
      totm_r    <= tm_sat;
      totr_r    <= tr_sat;
      verdict_r <= m_fail ? V_MSG : (r_fail ? V_RCP : V_OK);
      allow_r   <= !m_fail && !r_fail;
      start_r   <= now_r - 32'(div_rem);
    end
  end

  // result register
  logic        out_valid_r;
  logic [1:0]  out_verdict_r;
  logic [30:0] out_tm_r, out_tr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_verdict_r <= verdict_r;
      out_tm_r      <= totm_r;
      out_tr_r      <= totr_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_verdict          = out_verdict_r;
  assign out_total_messages   = out_tm_r;
  assign out_total_recipients = out_tr_r;

  assign sts.skip      = skip_r;
  assign sts.fill_zero = (meta_rd_r.fill == '0);
  assign sts.walk_last = (FW'(i_r) == fill_orig_r - 1'b1);
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || !out_stall;
  assign sts.clr_last  = (clr_r == ACW'(ACCOUNTS - 1));
endmodule
`default_nettype wire

[hdl/bucketed_account_quota.sv]
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                                             | Direction
// in      | in_valid, in_stall, in_account_index .. in_now_seconds | request in
// out     | out_valid, out_stall, out_verdict, out_total_*    | result out
//
// One request at a time: each accept is followed by metadata, a ring walk over the
// live buckets (a read and an update step per bucket on one memory port) while the
// 32-step remainder unit runs, then commit and finish; skips go straight to finish.
// After reset, in_stall stays high while the per-account ring metadata table clears.
// A result held by out_stall does not block the next request from being taken.
module bucketed_account_quota #(
  parameter int unsigned ACCOUNTS = baq_pkg::ACCOUNTS_DEF,
  parameter int unsigned BUCKETS  = baq_pkg::BUCKETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [9:0]  in_account_index,
  input  wire logic        in_add_messages,
  input  wire logic [15:0] in_add_recipients,
  input  wire logic [30:0] in_message_limit,
  input  wire logic [30:0] in_recipient_limit,
  input  wire logic [7:0]  in_period_hours,
  input  wire logic [31:0] in_now_seconds,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_verdict,
  output logic [30:0]      out_total_messages,
  output logic [30:0]      out_total_recipients
);
  import baq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  baq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  baq_dp #(
    .ACCOUNTS (ACCOUNTS),
    .BUCKETS  (BUCKETS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_account_index     (in_account_index),
    .in_add_messages      (in_add_messages),
    .in_add_recipients    (in_add_recipients),
    .in_message_limit     (in_message_limit),
    .in_recipient_limit   (in_recipient_limit),
    .in_period_hours      (in_period_hours),
    .in_now_seconds       (in_now_seconds),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_verdict          (out_verdict),
    .out_total_messages   (out_total_messages),
    .out_total_recipients (out_total_recipients)
  );
endmodule
`default_nettype wire
